@@ rtl/pulse_interval_miller_frame_decoder_assert.svh @@
// Assertion macros used by the frame decoder top level.
`ifndef PULSE_INTERVAL_MILLER_FRAME_DECODER_ASSERT_SVH
`define PULSE_INTERVAL_MILLER_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIMFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PIMFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pimfd_pkg.sv @@
package pimfd_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_SHORT_CENTER     = 3'd0;
	localparam logic [2:0] REG_MEDIUM_CENTER    = 3'd1;
	localparam logic [2:0] REG_LONG_CENTER      = 3'd2;
	localparam logic [2:0] REG_WINDOW_TOLERANCE = 3'd3;
	localparam logic [2:0] REG_END_THRESHOLD    = 3'd4;
	localparam logic [2:0] REG_MAX_FRAME_BYTES  = 3'd5;

	// Register reset values
	localparam logic [15:0] RST_SHORT_CENTER     = 16'd90;
	localparam logic [15:0] RST_MEDIUM_CENTER    = 16'd155;
	localparam logic [15:0] RST_LONG_CENTER      = 16'd220;
	localparam logic [15:0] RST_WINDOW_TOLERANCE = 16'd20;
	localparam logic [15:0] RST_END_THRESHOLD    = 16'd240;
	localparam logic [6:0]  RST_MAX_FRAME_BYTES  = 7'd20;

	// Gap classes
	localparam logic [1:0] GAP_INVALID = 2'd0;
	localparam logic [1:0] GAP_SHORT   = 2'd1;
	localparam logic [1:0] GAP_MEDIUM  = 2'd2;
	localparam logic [1:0] GAP_LONG    = 2'd3;

	// Frame status codes
	localparam logic [2:0] ST_OK              = 3'd0;
	localparam logic [2:0] ST_BAD_GAP         = 3'd1;
	localparam logic [2:0] ST_BAD_START       = 3'd2;
	localparam logic [2:0] ST_LONG_AFTER_ZERO = 3'd3;
	localparam logic [2:0] ST_OVERFLOW        = 3'd4;
	localparam logic [2:0] ST_BAD_LENGTH      = 3'd5;

	// Result kinds
	localparam logic RK_BYTE = 1'b0;
	localparam logic RK_END  = 1'b1;

	// Short frame length in bits
	localparam logic [9:0] SHORT_FRAME_BITS = 10'd7;

	typedef struct packed {
		logic [15:0] short_center;
		logic [15:0] medium_center;
		logic [15:0] long_center;
		logic [15:0] window_tolerance;
		logic [15:0] end_threshold;
		logic [6:0]  max_frame_bytes;
	} cfg_t;

	typedef struct packed {
		logic       is_end;
		logic [1:0] kind;
	} gap_class_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] data_byte;
		logic       received_parity;
		logic       expected_parity;
		logic [2:0] frame_status;
		logic [9:0] bit_count;
		logic       last_bit;
	} result_t;

endpackage

@@ rtl/pimfd_classify.sv @@
module pimfd_classify import pimfd_pkg::*; (
	input  logic [15:0] gap,
	input  cfg_t        cfg,
	output gap_class_t  cls
);

	// Open window test: centre - tol < gap < centre + tol, kept in 17 bits
	function automatic logic in_window(input logic [15:0] g, input logic [15:0] c,
			input logic [15:0] t);
		logic [16:0] lo_sum;
		logic [16:0] hi_sum;
		lo_sum = {1'b0, g} + {1'b0, t};
		hi_sum = {1'b0, c} + {1'b0, t};
		return (lo_sum > {1'b0, c}) && ({1'b0, g} < hi_sum);
	endfunction

	logic hit_short, hit_medium, hit_long;

	assign hit_short  = in_window(gap, cfg.short_center, cfg.window_tolerance);
	assign hit_medium = in_window(gap, cfg.medium_center, cfg.window_tolerance);
	assign hit_long   = in_window(gap, cfg.long_center, cfg.window_tolerance);

	// Priority: short, then medium, then long
	always_comb begin
		cls.is_end = (gap >= cfg.end_threshold);
		if (hit_short) begin
			cls.kind = GAP_SHORT;
		end else if (hit_medium) begin
			cls.kind = GAP_MEDIUM;
		end else if (hit_long) begin
			cls.kind = GAP_LONG;
		end else begin
			cls.kind = GAP_INVALID;
		end
	end

endmodule

@@ rtl/pimfd_decoder.sv @@
module pimfd_decoder import pimfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  gap_class_t cls,
	input  logic [6:0] max_frame_bytes,
	output logic       has_result,
	output result_t    result
);

	typedef struct packed {
		logic       awaiting;
		logic       prev;
		logic [3:0] pos;
		logic [6:0] total;
		logic       par;
		logic [7:0] shifter;
		logic       final_bit;
		logic [2:0] err;
	} frame_t;

	typedef struct packed {
		logic       ready;
		logic [7:0] data;
		logic       rpar;
		logic       rexp;
	} byte_evt_t;

	localparam frame_t FRAME_CLEAR = '{awaiting: 1'b1, default: '0};

	// Append one bit; the ninth bit is parity and closes the byte
	function automatic frame_t add_bit(input frame_t f, input logic b,
			output byte_evt_t ev);
		frame_t n;
		n  = f;
		ev = '0;
		if (f.pos < 4'd8) begin
			n.par                 = f.par ^ b;
			n.shifter[f.pos[2:0]] = b;
			n.pos                 = f.pos + 4'd1;
		end else begin
			ev.ready  = 1'b1;
			ev.data   = f.shifter;
			ev.rpar   = b;
			ev.rexp   = ~f.par;
			n.total   = f.total + 7'd1;
			n.pos     = '0;
			n.par     = 1'b0;
			n.shifter = '0;
		end
		return n;
	endfunction

	frame_t    cur_q;
	frame_t    nxt;
	byte_evt_t ev0, ev1, ev;

	// Decode of one gap against the current frame state
	always_comb begin
		nxt        = cur_q;
		ev0        = '0;
		ev1        = '0;
		ev         = '0;
		has_result = 1'b0;
		result     = '0;
		if (cls.is_end) begin
			// End of frame: report, then clear (nothing to report before a start)
			if (!cur_q.awaiting) begin
				has_result         = 1'b1;
				result.result_kind = RK_END;
				result.last_bit    = cur_q.final_bit;
				if (cur_q.err != ST_OK) begin
					result.frame_status = cur_q.err;
				end else if (cur_q.pos == 4'd0) begin
					result.bit_count = {cur_q.total, 3'b000};
				end else if (cur_q.pos == 4'd7 && cur_q.total == 7'd0) begin
					result.bit_count = SHORT_FRAME_BITS;
					result.data_byte = {1'b0, cur_q.shifter[6:0]};
				end else begin
					result.frame_status = ST_BAD_LENGTH;
				end
				nxt = FRAME_CLEAR;
			end
		end else if (cur_q.awaiting) begin
			// Start gap
			nxt.awaiting = 1'b0;
			case (cls.kind)
				GAP_INVALID: nxt.err = ST_BAD_GAP;
				GAP_LONG:    nxt.err = ST_BAD_START;
				GAP_MEDIUM: begin
					nxt           = add_bit(nxt, 1'b1, ev0);
					nxt.prev      = 1'b1;
					nxt.final_bit = 1'b1;
				end
				default: ;
			endcase
		end else if (cur_q.err == ST_OK) begin
			// Data gap, modified Miller rules on the previous bit
			case (cls.kind)
				GAP_INVALID: nxt.err = ST_BAD_GAP;
				GAP_SHORT: begin
					nxt           = add_bit(nxt, cur_q.prev, ev0);
					nxt.final_bit = cur_q.prev;
				end
				GAP_MEDIUM: begin
					nxt = add_bit(nxt, 1'b0, ev0);
					if (!cur_q.prev) begin
						nxt = add_bit(nxt, 1'b1, ev1);
					end
					nxt.prev      = ~cur_q.prev;
					nxt.final_bit = ~cur_q.prev;
				end
				default: begin
					if (!cur_q.prev) begin
						nxt.err = ST_LONG_AFTER_ZERO;
					end else begin
						nxt           = add_bit(nxt, 1'b0, ev0);
						nxt           = add_bit(nxt, 1'b1, ev1);
						nxt.prev      = 1'b1;
						nxt.final_bit = 1'b1;
					end
				end
			endcase
			// Overflow check after a decoded gap
			if (nxt.err == ST_OK && nxt.total >= max_frame_bytes) begin
				nxt.err = ST_OVERFLOW;
			end
			ev = ev0.ready ? ev0 : ev1;
			if (ev.ready) begin
				has_result             = 1'b1;
				result.result_kind     = RK_BYTE;
				result.data_byte       = ev.data;
				result.received_parity = ev.rpar;
				result.expected_parity = ev.rexp;
			end
		end
	end

	// Frame state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= FRAME_CLEAR;
		end else if (advance) begin
			cur_q <= nxt;
		end
	end

endmodule

@@ rtl/pulse_interval_miller_frame_decoder.sv @@
// Modified Miller frame decoder working on measured pulse gaps.
// Input stream s_*: one gap per transaction, s_tdata[15:0] = gap_ticks.
// Output stream m_*: one result per transaction; m_tuser = result_kind
// (0 completed byte, 1 end of frame report), m_tdata holds the rest.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 short
// centre, 1 medium centre, 2 long centre, 3 tolerance, 4 end threshold,
// 5 max frame bytes); write only while the block is idle.
// A gap from s_* waits in the input register and is decoded when stage 1
// advances; its result is registered onto m_*. Throughput: one gap per
// cycle while m_* is not stalled; the window compares and the bit assembly
// sit in one stage. A gap giving no result still occupies the stage.
// Reset clears the frame state and the pipeline and loads default windows.
// When m_tready is low with a result waiting, the stage holds its gap and
// s_tready drops once that stage is full; nothing is lost or repeated.
`include "pulse_interval_miller_frame_decoder_assert.svh"

module pulse_interval_miller_frame_decoder import pimfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] gap_ticks
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] data_byte, [8] received_parity,
	                               // [9] expected_parity, [12:10] frame_status,
	                               // [22:13] bit_count, [23] last_bit
	output logic        m_tuser    // [0] result_kind
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [15:0] gap_s1;
	logic       adv_s1;
	gap_class_t cls;
	logic       has_result;
	result_t    result;
	logic       m_valid_q;
	result_t    m_result_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_center     <= RST_SHORT_CENTER;
			cfg_q.medium_center    <= RST_MEDIUM_CENTER;
			cfg_q.long_center      <= RST_LONG_CENTER;
			cfg_q.window_tolerance <= RST_WINDOW_TOLERANCE;
			cfg_q.end_threshold    <= RST_END_THRESHOLD;
			cfg_q.max_frame_bytes  <= RST_MAX_FRAME_BYTES;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SHORT_CENTER:     cfg_q.short_center     <= cfg_wdata;
				REG_MEDIUM_CENTER:    cfg_q.medium_center    <= cfg_wdata;
				REG_LONG_CENTER:      cfg_q.long_center      <= cfg_wdata;
				REG_WINDOW_TOLERANCE: cfg_q.window_tolerance <= cfg_wdata;
				REG_END_THRESHOLD:    cfg_q.end_threshold    <= cfg_wdata;
				REG_MAX_FRAME_BYTES:  cfg_q.max_frame_bytes  <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// Stage 1 moves on when the output register has room
	assign adv_s1   = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			gap_s1 <= s_tdata;
		end
	end

	pimfd_classify u_classify (
		.gap (gap_s1),
		.cfg (cfg_q),
		.cls (cls)
	);

	pimfd_decoder u_decoder (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (adv_s1),
		.cls             (cls),
		.max_frame_bytes (cfg_q.max_frame_bytes),
		.has_result      (has_result),
		.result          (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1 && has_result) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_result) begin
			m_result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_result_q.result_kind;
	assign m_tdata  = {m_result_q.last_bit, m_result_q.bit_count, m_result_q.frame_status,
		m_result_q.expected_parity, m_result_q.received_parity, m_result_q.data_byte};

	// Checks
	`PIMFD_ASSERT_NOW(a_adv_room, clk, arst_n, adv_s1, (!m_valid_q || m_tready),
		"stage 1 advanced into a full output register")
	`PIMFD_ASSERT_NEXT(a_s1_hold, clk, arst_n, (valid_s1 && !adv_s1),
		(valid_s1 && $stable(gap_s1)), "stalled gap in stage 1 was lost or changed")
	`PIMFD_ASSERT_NOW(a_byte_clean, clk, arst_n, (m_valid_q && m_tuser == RK_BYTE),
		(m_result_q.frame_status == ST_OK && m_result_q.bit_count == 10'd0 &&
		!m_result_q.last_bit), "byte result carries frame report fields")
	`PIMFD_ASSERT_NOW(a_err_zero_count, clk, arst_n,
		(m_valid_q && m_tuser == RK_END && m_result_q.frame_status != ST_OK),
		(m_result_q.bit_count == 10'd0 && m_result_q.data_byte == 8'd0),
		"failed frame reports a length or data")

endmodule
